@@ hdl/bgp_pkg.sv @@
// Shared types and constants for the bilinear grid prolongation block.
// Used by every module of the block but bgp_ram; depends on nothing.
`default_nettype none
package bgp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_COARSE_COLS   = 3'd0;
  localparam logic [2:0] REG_COARSE_ROWS   = 3'd1;
  localparam logic [2:0] REG_OMEGA         = 3'd2;
  localparam logic [2:0] REG_BILINEAR_MODE = 3'd3;
  localparam logic [2:0] REG_SOLUTION_MODE = 3'd4;

  // Item kinds carried on tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_FINE = 1'b1;

  // Field widths.
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STORE_W = 33;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned OMEGA_W = 16;
  localparam int unsigned SUM_W   = 38;
  localparam int unsigned PROD_W  = SUM_W + OMEGA_W + 1;
  localparam int unsigned FRAC_SH = 19;

  // Unity relaxation factor in Q1.15.
  localparam logic [OMEGA_W-1:0] OMEGA_ONE = 16'h8000;

  // Grid checks produced by the address generator.
  typedef struct packed {
    logic load_ok;
    logic fine_ok;
  } bgp_flags_t;

endpackage
`default_nettype wire

@@ hdl/bgp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none
module bgp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hdl/bgp_addr.sv @@
// Address generator: effective grid size, grid checks, parent and neighbor
// addresses with periodic columns and clamped rows. Depends on bgp_pkg.
`default_nettype none
module bgp_addr
  import bgp_pkg::*;
#(
  parameter int unsigned MAX_COARSE_COLS = 128,
  parameter int unsigned MAX_COARSE_ROWS = 128,
  localparam int unsigned CW = (MAX_COARSE_COLS > 1) ? $clog2(MAX_COARSE_COLS) : 1,
  localparam int unsigned RW = (MAX_COARSE_ROWS > 1) ? $clog2(MAX_COARSE_ROWS) : 1,
  localparam int unsigned AW = CW + RW
) (
  input  wire logic [POS_W-1:0] cols_i,
  input  wire logic [POS_W-1:0] rows_i,
  input  wire logic [POS_W-1:0] col_i,
  input  wire logic [POS_W-1:0] row_i,
  output bgp_flags_t            flags_o,
  output logic      [AW-1:0]    addr_pp_o,
  output logic      [AW-1:0]    addr_qp_o,
  output logic      [AW-1:0]    addr_pq_o,
  output logic      [AW-1:0]    addr_qq_o,
  output logic      [AW-1:0]    addr_load_o
);

  localparam int unsigned MW = (CW > RW) ? CW : RW;
  localparam int unsigned WW = (MW + 2 > POS_W + 2) ? MW + 2 : POS_W + 2;
  localparam logic [WW-1:0] MAXC = WW'(MAX_COARSE_COLS);
  localparam logic [WW-1:0] MAXR = WW'(MAX_COARSE_ROWS);
  localparam logic [WW-1:0] ONE  = WW'(1);

  logic [WW-1:0] rawc, rawr, nc, nr, colw, roww, pc, pr, qc, qr;

  always_comb begin
    rawc = WW'(cols_i);
    rawr = WW'(rows_i);
    colw = WW'(col_i);
    roww = WW'(row_i);

    // Zero counts as one cell; large values saturate at the build maximum.
    nc = (rawc == '0) ? ONE : ((rawc > MAXC) ? MAXC : rawc);
    nr = (rawr == '0) ? ONE : ((rawr > MAXR) ? MAXR : rawr);

    flags_o.load_ok = (colw < nc) && (roww < nr);
    flags_o.fine_ok = (colw < (nc << 1)) && (roww < (nr << 1));

    // Parent cell and the neighbor on the side of the fine cell.
    pc = colw >> 1;
    pr = roww >> 1;
    if (col_i[0]) begin
      qc = (pc + ONE == nc) ? '0 : pc + ONE;
    end else begin
      qc = (pc == '0) ? nc - ONE : pc - ONE;
    end
    if (row_i[0]) begin
      qr = (pr + ONE == nr) ? pr : pr + ONE;
    end else begin
      qr = (pr == '0) ? pr : pr - ONE;
    end

    addr_pp_o   = {pr[RW-1:0], pc[CW-1:0]};
    addr_qp_o   = {pr[RW-1:0], qc[CW-1:0]};
    addr_pq_o   = {qr[RW-1:0], pc[CW-1:0]};
    addr_qq_o   = {qr[RW-1:0], qc[CW-1:0]};
    addr_load_o = {roww[RW-1:0], colw[CW-1:0]};
  end

endmodule
`default_nettype wire

@@ hdl/bgp_lane.sv @@
// One component lane: stencil sum, scaling by the relaxation factor, rounding,
// fine-value add and saturation over three registered steps. Depends on bgp_pkg.
`default_nettype none
module bgp_lane
  import bgp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_sum_i,
  input  wire logic                en_mul_i,
  input  wire logic                en_out_i,
  input  wire logic                bilinear_i,
  input  wire logic                solution_i,
  input  wire logic [OMEGA_W-1:0]  weight_i,
  input  wire logic [STORE_W-1:0]  a_i,
  input  wire logic [STORE_W-1:0]  b_i,
  input  wire logic [STORE_W-1:0]  c_i,
  input  wire logic [STORE_W-1:0]  d_i,
  input  wire logic [VAL_W-1:0]    fine_i,
  output logic      [VAL_W-1:0]    out_o
);

  localparam int unsigned RND_W = PROD_W - FRAC_SH;
  localparam int unsigned ACC_W = RND_W + 1;

  logic signed [SUM_W-1:0]  sa, sb, sc, sd, sum_d, sum_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [VAL_W-1:0]  fine_sum_q, fine_mul_q, addend;
  logic signed [RND_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  acc;
  logic        [VAL_W-1:0]  out_d, out_q;

  // Weighted stencil 9/3/3/1, or sixteen times the parent for injection.
  always_comb begin
    sa = SUM_W'($signed(a_i));
    sb = SUM_W'($signed(b_i));
    sc = SUM_W'($signed(c_i));
    sd = SUM_W'($signed(d_i));
    if (bilinear_i) begin
      sum_d = (sa <<< 3) + sa + (sb <<< 1) + sb + (sc <<< 1) + sc + sd;
    end else begin
      sum_d = sa <<< 4;
    end
  end

  // Solution mode uses a unit weight so the shift by 19 equals rounding by 16.
  assign prod_d = sum_q * $signed({1'b0, (solution_i ? OMEGA_ONE : weight_i)});

  // Round half up, add the fine value unless replacing, then saturate.
  always_comb begin
    rnd    = RND_W'((prod_q + PROD_W'(64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH);
    addend = solution_i ? '0 : fine_mul_q;
    acc    = ACC_W'(rnd) + ACC_W'(addend);
    if (acc > ACC_W'(64'sh7FFFFFFF)) begin
      out_d = 32'h7FFFFFFF;
    end else if (acc < -ACC_W'(64'sh80000000)) begin
      out_d = 32'h80000000;
    end else begin
      out_d = acc[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_sum_i) begin
      sum_q      <= sum_d;
      fine_sum_q <= $signed(fine_i);
    end
    if (en_mul_i) begin
      prod_q     <= prod_d;
      fine_mul_q <= fine_sum_q;
    end
    if (en_out_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule
`default_nettype wire

@@ hdl/bilinear_grid_prolongation.sv @@
// Top level of the bilinear grid prolongation block: configuration registers,
// coarse-store RAM copies, lane array and output stage. Depends on bgp_pkg,
// bgp_addr, bgp_ram and bgp_lane.
//
// The block accepts one beat per clock cycle, loads and fine cells alike, while
// the output is not stalled. A fine cell's result passes the RAM read, stencil
// sum, product and output registers. Four copies of the coarse store, written
// together on every load, give the four stencil reads of a fine cell in the same
// cycle, and one arithmetic lane per component turns them into the result. A
// load is visible to a fine cell in the very next beat. The coarse store is not
// cleared by reset: every coarse cell a fine cell touches must be loaded first.
// Configuration must be written only while no fine cell is in flight.
`default_nettype none
module bilinear_grid_prolongation
  import bgp_pkg::*;
#(
  parameter int unsigned MAX_COARSE_COLS = 128,
  parameter int unsigned MAX_COARSE_ROWS = 128,
  parameter int unsigned COMPONENTS      = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Fields from bit 0: col, row, value_0.., pre_0..
  input  wire logic [2*POS_W+2*COMPONENTS*VAL_W-1:0] s_axis_tdata,
  // Fields from bit 0: kind
  input  wire logic                                 s_axis_tuser,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // Fields from bit 0: out_0, out_1, ..
  output logic      [COMPONENTS*VAL_W-1:0]          m_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [2:0]                           cfg_index_i,
  input  wire logic [OMEGA_W-1:0]                   cfg_data_i
);

  localparam int unsigned CW = (MAX_COARSE_COLS > 1) ? $clog2(MAX_COARSE_COLS) : 1;
  localparam int unsigned RW = (MAX_COARSE_ROWS > 1) ? $clog2(MAX_COARSE_ROWS) : 1;
  localparam int unsigned AW = CW + RW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned WORD_W = COMPONENTS * STORE_W;
  localparam int unsigned VOFS = 2 * POS_W;
  localparam int unsigned POFS = VOFS + COMPONENTS * VAL_W;

  // Configuration registers.
  logic [POS_W-1:0]   cols_q, rows_q;
  logic [OMEGA_W-1:0] omega_q, weight;
  logic               bil_q, sol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= 8'd128;
      rows_q  <= 8'd128;
      omega_q <= OMEGA_ONE;
      bil_q   <= 1'b1;
      sol_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COARSE_COLS:   cols_q  <= cfg_data_i[POS_W-1:0];
        REG_COARSE_ROWS:   rows_q  <= cfg_data_i[POS_W-1:0];
        REG_OMEGA:         omega_q <= cfg_data_i;
        REG_BILINEAR_MODE: bil_q   <= cfg_data_i[0];
        REG_SOLUTION_MODE: sol_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign weight = (omega_q > OMEGA_ONE) ? OMEGA_ONE : omega_q;

  // Addresses and grid checks for the incoming beat.
  bgp_flags_t     flags;
  logic [AW-1:0]  a_pp, a_qp, a_pq, a_qq, a_ld;

  bgp_addr #(
    .MAX_COARSE_COLS(MAX_COARSE_COLS),
    .MAX_COARSE_ROWS(MAX_COARSE_ROWS)
  ) u_addr (
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .col_i       (s_axis_tdata[POS_W-1:0]),
    .row_i       (s_axis_tdata[2*POS_W-1:POS_W]),
    .flags_o     (flags),
    .addr_pp_o   (a_pp),
    .addr_qp_o   (a_qp),
    .addr_pq_o   (a_pq),
    .addr_qq_o   (a_qq),
    .addr_load_o (a_ld)
  );

  // Pipeline control: each stage moves when the next one is free or moving.
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy_o, rdy3, rdy2, rdy1, acc_beat, fine_go, load_we;

  assign rdy_o         = !vo_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy_o;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign acc_beat      = s_axis_tvalid && s_axis_tready;
  assign fine_go       = acc_beat && (s_axis_tuser == KIND_FINE) && flags.fine_ok;
  assign load_we       = acc_beat && (s_axis_tuser == KIND_LOAD) && flags.load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= fine_go;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy_o) vo_q <= v3_q;
    end
  end

  // Coarse word: value minus pre-smoothing value, or value alone.
  logic [WORD_W-1:0] wword;
  always_comb begin
    for (int k = 0; k < COMPONENTS; k++) begin
      if (sol_q) begin
        wword[k*STORE_W +: STORE_W] =
          STORE_W'($signed(s_axis_tdata[VOFS + k*VAL_W +: VAL_W]));
      end else begin
        wword[k*STORE_W +: STORE_W] =
          STORE_W'($signed(s_axis_tdata[VOFS + k*VAL_W +: VAL_W]))
          - STORE_W'($signed(s_axis_tdata[POFS + k*VAL_W +: VAL_W]));
      end
    end
  end

  // Four store copies, one per stencil tap.
  logic [WORD_W-1:0] rd_pp, rd_qp, rd_pq, rd_qq;

  bgp_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_pp (
    .clk_i, .we_i(load_we), .waddr_i(a_ld), .wdata_i(wword),
    .re_i(fine_go), .raddr_i(a_pp), .rdata_o(rd_pp)
  );
  bgp_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_qp (
    .clk_i, .we_i(load_we), .waddr_i(a_ld), .wdata_i(wword),
    .re_i(fine_go), .raddr_i(a_qp), .rdata_o(rd_qp)
  );
  bgp_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_pq (
    .clk_i, .we_i(load_we), .waddr_i(a_ld), .wdata_i(wword),
    .re_i(fine_go), .raddr_i(a_pq), .rdata_o(rd_pq)
  );
  bgp_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_qq (
    .clk_i, .we_i(load_we), .waddr_i(a_ld), .wdata_i(wword),
    .re_i(fine_go), .raddr_i(a_qq), .rdata_o(rd_qq)
  );

  // Fine values travel beside the RAM read.
  logic [COMPONENTS*VAL_W-1:0] fine1_q;
  always_ff @(posedge clk_i) begin
    if (fine_go) begin
      fine1_q <= s_axis_tdata[VOFS +: COMPONENTS*VAL_W];
    end
  end

  // Lane array; the output stage merges the lanes into one beat.
  logic en_sum, en_mul, en_out;
  assign en_sum = v1_q && rdy2;
  assign en_mul = v2_q && rdy3;
  assign en_out = v3_q && rdy_o;

  for (genvar k = 0; k < COMPONENTS; k++) begin : g_lane
    bgp_lane u_lane (
      .clk_i      (clk_i),
      .en_sum_i   (en_sum),
      .en_mul_i   (en_mul),
      .en_out_i   (en_out),
      .bilinear_i (bil_q),
      .solution_i (sol_q),
      .weight_i   (weight),
      .a_i        (rd_pp[k*STORE_W +: STORE_W]),
      .b_i        (rd_qp[k*STORE_W +: STORE_W]),
      .c_i        (rd_pq[k*STORE_W +: STORE_W]),
      .d_i        (rd_qq[k*STORE_W +: STORE_W]),
      .fine_i     (fine1_q[k*VAL_W +: VAL_W]),
      .out_o      (m_axis_tdata[k*VAL_W +: VAL_W])
    );
  end

  assign m_axis_tvalid = vo_q;

endmodule
`default_nettype wire

@@ hdl/bgp_checker.sv @@
// Port-level checker for the bilinear grid prolongation block, bound to the
// top level. Depends on bgp_pkg.
`default_nettype none
module bgp_checker
  import bgp_pkg::*;
#(
  parameter int unsigned COMPONENTS = 4
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [COMPONENTS*VAL_W-1:0]  m_axis_tdata,
  input wire logic                         cfg_ready_o
);

  // With no result pending the input side is never held off.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A stalled result beat stays and keeps its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // A rising result needs an earlier accepted input beat, unless stalls or earlier results intervene.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && $past(rst_ni, 4) |->
      $past(s_axis_tvalid && s_axis_tready, 4) || $past(m_axis_tvalid, 2)
      || $past(m_axis_tvalid, 3) || $past(m_axis_tvalid, 4)
      || $past(!s_axis_tready, 4) || $past(!s_axis_tready, 3)
      || $past(!s_axis_tready, 2))
    else $error("result without a matching input beat");

  // The configuration channel never back-pressures.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration channel not ready");

endmodule

bind bilinear_grid_prolongation bgp_checker #(.COMPONENTS(COMPONENTS)) u_bgp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for bilinear_grid_prolongation: random and directed
// load and fine-cell beats, predicted results in a scoreboard queue.
// Depends on bgp_pkg and the block's RTL only.
`default_nettype none
module tb_top;
  import bgp_pkg::*;

  localparam int MAXC = 128;
  localparam int MAXR = 128;
  localparam int NCOMP = 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic                kind;
    logic [7:0]          col;
    logic [7:0]          row;
    logic [3:0][31:0]    val;
    logic [3:0][31:0]    pre;
  } cell_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [2*POS_W+2*NCOMP*VAL_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [NCOMP*VAL_W-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [OMEGA_W-1:0] cfg_data_i = '0;

  bilinear_grid_prolongation uut (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Shadow configuration and coarse store of the predictor.
  int unsigned cols_reg = 128, rows_reg = 128, omega_reg = 32768;
  bit bilinear_reg = 1'b1, solution_reg = 1'b0;
  longint coarse_mem [MAXC*MAXR][NCOMP];
  bit loaded_gen [MAXC*MAXR];

  cell_beat_t pending_beats[$];
  logic [3:0][31:0] fine_results[$];
  bit quiet = 1'b0;
  int errors = 0, beats_sent = 0, results_seen = 0, phases_run = 0;
  int unsigned cycles = 0;

  function automatic int eff_size(int unsigned r, int unsigned max_v);
    if (r == 0) return 1;
    return (r > max_v) ? max_v : r;
  endfunction

  // Coarse store address with periodic columns and clamped rows.
  function automatic int cell_addr(int c, int r);
    int nc, nr, ci;
    nc = eff_size(cols_reg, MAXC);
    nr = eff_size(rows_reg, MAXR);
    ci = c % nc;
    if (ci < 0) ci += nc;
    if (r < 0) r = 0;
    if (r > nr - 1) r = nr - 1;
    return r * MAXC + ci;
  endfunction

  function automatic longint round_sh(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Append one beat to the stimulus queue.
  task automatic add_beat(cell_beat_t b);
    pending_beats = {pending_beats, b};
  endtask

  // Update the store on a load, or queue the expected fine-cell result.
  task automatic predict_beat(cell_beat_t b);
    int nc, nr, pc, pr, qc, qr, a;
    longint s, w;
    logic [3:0][31:0] res;
    nc = eff_size(cols_reg, MAXC);
    nr = eff_size(rows_reg, MAXR);
    if (b.kind == KIND_LOAD) begin
      if (b.col < nc && b.row < nr) begin
        a = b.row * MAXC + b.col;
        for (int k = 0; k < NCOMP; k++) begin
          coarse_mem[a][k] = longint'($signed(b.val[k]));
          if (!solution_reg) coarse_mem[a][k] -= longint'($signed(b.pre[k]));
        end
      end
      return;
    end
    if (b.col >= 2 * nc || b.row >= 2 * nr) return;
    pc = b.col >> 1;
    pr = b.row >> 1;
    qc = b.col[0] ? pc + 1 : pc - 1;
    qr = b.row[0] ? pr + 1 : pr - 1;
    w = (omega_reg > 32768) ? 32768 : omega_reg;
    for (int k = 0; k < NCOMP; k++) begin
      if (bilinear_reg)
        s = 9 * coarse_mem[cell_addr(pc, pr)][k] + 3 * coarse_mem[cell_addr(qc, pr)][k]
          + 3 * coarse_mem[cell_addr(pc, qr)][k] + coarse_mem[cell_addr(qc, qr)][k];
      else
        s = 16 * coarse_mem[cell_addr(pc, pr)][k];
      if (solution_reg) res[k] = sat32(round_sh(s, 4));
      else res[k] = sat32(longint'($signed(b.val[k])) + round_sh(s * w, FRAC_SH));
    end
    fine_results = {fine_results, res};
  endtask

  // Clock, reset and cycle limit.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Input driver with random idle bursts.
  cell_beat_t cur_beat;
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(cur_beat);
        beats_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          s_axis_tdata <= {cur_beat.pre, cur_beat.val, cur_beat.row, cur_beat.col};
          s_axis_tuser <= cur_beat.kind;
          s_axis_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random stall bursts.
  int stall;
  always @(posedge clk_i or negedge rst_ni) begin
    logic [3:0][31:0] exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (fine_results.size() == 0) begin
          $error("result beat with no expectation waiting: %h", m_axis_tdata);
          errors++;
        end else begin
          exp_res = fine_results.pop_front();
          for (int k = 0; k < NCOMP; k++)
            if (m_axis_tdata[k*32 +: 32] !== exp_res[k]) begin
              $error("out_%0d mismatch: expected %h, actual %h", k, exp_res[k],
                     m_axis_tdata[k*32 +: 32]);
              errors++;
            end
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 17);
      end
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_beat_t make_beat(logic kind, int c, int r);
    cell_beat_t b;
    b.kind = kind;
    b.col = c[7:0];
    b.row = r[7:0];
    for (int k = 0; k < NCOMP; k++) begin
      b.val[k] = rand_val();
      b.pre[k] = rand_val();
    end
    return b;
  endfunction

  // Queue a load and note which coarse cells now hold data.
  task automatic queue_load(int c, int r);
    if (c < eff_size(cols_reg, MAXC) && r < eff_size(rows_reg, MAXR))
      loaded_gen[r * MAXC + c] = 1'b1;
    add_beat(make_beat(KIND_LOAD, c, r));
  endtask

  // A fine cell may be sent if it lies outside the grid or its stencil is loaded.
  function automatic bit fine_allowed(int c, int r);
    int pc, pr, qc, qr;
    if (c >= 2 * eff_size(cols_reg, MAXC) || r >= 2 * eff_size(rows_reg, MAXR)) return 1;
    pc = c >> 1;
    pr = r >> 1;
    qc = c[0] ? pc + 1 : pc - 1;
    qr = r[0] ? pr + 1 : pr - 1;
    if (!loaded_gen[cell_addr(pc, pr)]) return 0;
    if (!bilinear_reg) return 1;
    return loaded_gen[cell_addr(qc, pr)] && loaded_gen[cell_addr(pc, qr)]
        && loaded_gen[cell_addr(qc, qr)];
  endfunction

  // Wait until nothing is pending or in flight, then let the pipeline drain.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || s_axis_tvalid || fine_results.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  // Drive one register write; the caller drops valid after the last one.
  task automatic write_reg(logic [2:0] idx, int unsigned data);
    cfg_index_i <= idx;
    cfg_data_i <= data[15:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      REG_COARSE_COLS:   cols_reg = data & 8'hff;
      REG_COARSE_ROWS:   rows_reg = data & 8'hff;
      REG_OMEGA:         omega_reg = data & 16'hffff;
      REG_BILINEAR_MODE: bilinear_reg = data[0];
      REG_SOLUTION_MODE: solution_reg = data[0];
      default: ;
    endcase
  endtask

  // One phase: configure, preload coarse cells, then an optional directed sweep and a mixed random stream.
  task automatic run_phase(int unsigned nc_w, int unsigned nr_w, int unsigned om,
                           bit bil, bit sol, int n_rand, bit directed);
    int nc, nr, c, r;
    bit large_grid, found;
    wait_idle();
    write_reg(REG_COARSE_COLS, nc_w);
    write_reg(REG_COARSE_ROWS, nr_w);
    write_reg(REG_OMEGA, om);
    write_reg(REG_BILINEAR_MODE, bil);
    write_reg(REG_SOLUTION_MODE, sol);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    nc = eff_size(cols_reg, MAXC);
    nr = eff_size(rows_reg, MAXR);
    large_grid = (nc * nr > 64);
    if (large_grid) begin
      for (r = 0; r < 4; r++)
        for (int i = 0; i < 4; i++) begin
          queue_load(i, r);
          queue_load(nc - 1 - i, r);
        end
    end else begin
      for (r = 0; r < nr; r++)
        for (c = 0; c < nc; c++) queue_load(c, r);
    end
    // Directed sweep over every fine cell plus out-of-grid fine cells and an out-of-grid load.
    if (directed) begin
      for (r = 0; r < 2 * nr; r++)
        for (c = 0; c < 2 * nc; c++)
          add_beat(make_beat(KIND_FINE, c, r));
      add_beat(make_beat(KIND_FINE, 2 * nc, 0));
      add_beat(make_beat(KIND_FINE, 0, 2 * nr));
      add_beat(make_beat(KIND_FINE, 255, 255));
      add_beat(make_beat(KIND_LOAD, 255, 255));
    end
    for (int i = 0; i < n_rand; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        if ($urandom_range(0, 3) == 0) queue_load($urandom_range(0, 255), $urandom_range(0, 255));
        else if (large_grid) queue_load($urandom_range(0, 3), $urandom_range(0, 3));
        else queue_load($urandom_range(0, nc - 1), $urandom_range(0, nr - 1));
      end else begin
        found = 0;
        for (int t = 0; t < 40 && !found; t++) begin
          if ($urandom_range(0, 7) == 0) begin
            c = $urandom_range(0, 255);
            r = $urandom_range(0, 255);
          end else if (large_grid) begin
            c = $urandom_range(0, 1) ? $urandom_range(0, 7) : 2 * nc - 1 - $urandom_range(0, 7);
            r = $urandom_range(0, 7);
          end else begin
            c = $urandom_range(0, 2 * nc - 1);
            r = $urandom_range(0, 2 * nr - 1);
          end
          found = fine_allowed(c, r);
        end
        if (found) add_beat(make_beat(KIND_FINE, c, r));
      end
    end
    phases_run++;
  endtask

  // Phase sequence: extremes of every register, ending without idling.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    run_phase(4, 3, 32768, 1, 0, 30, 1);
    run_phase(128, 128, 32768, 1, 0, 40, 0);
    run_phase(1, 1, 0, 1, 1, 30, 0);
    run_phase(0, 0, 65535, 0, 0, 30, 0);
    run_phase(255, 255, 12345, 0, 1, 40, 0);
    run_phase(8, 5, 16384, 1, 1, 50, 0);
    run_phase(5, 2, 1, 0, 0, 40, 0);
    quiet = 1'b1;
    run_phase(2, 8, 32767, 1, 0, 40, 0);
    wait_idle();
    $display("Covered %0d phases of register settings, %0d input beats accepted,",
             phases_run, beats_sent);
    $display("%0d fine-cell results checked, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
hdl/bgp_pkg.sv
hdl/bgp_ram.sv
hdl/bgp_addr.sv
hdl/bgp_lane.sv
hdl/bilinear_grid_prolongation.sv
hdl/bgp_checker.sv
tb/tb_top.sv
